/* hw/rtl/fsg_pkg.sv */
package fsg_pkg;

    localparam int GRID_ROWS_DEFAULT    = 32;
    localparam int GRID_COLUMNS_DEFAULT = 64;
    localparam int MAX_EMIT             = 32;

    localparam int COLUMN_W     = 6;
    localparam int ROW_W        = 5;
    localparam int KIND_W       = 2;
    localparam int HALF_W       = 64;
    localparam int ROW_NUMBER_W = 5;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_AIR    = 2'd0,
        KIND_SAND   = 2'd1,
        KIND_WATER  = 2'd2,
        KIND_CEMENT = 2'd3
    } particle_t;

    typedef enum logic [2:0] {
        MOVE_NONE,
        MOVE_DOWN,
        MOVE_DOWN_LEFT,
        MOVE_DOWN_RIGHT,
        MOVE_LEFT,
        MOVE_RIGHT
    } move_t;

    typedef struct packed {
        particle_t own;
        particle_t below;
        particle_t below_left;
        particle_t below_right;
        particle_t left;
        particle_t right;
        logic      has_below;
        logic      has_left;
        logic      has_right;
    } neighbor_t;

endpackage

/* hw/rtl/fsg_cmd_if.sv */
interface fsg_cmd_if
    import fsg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [KIND_W-1:0]   particle_kind;

    modport source (
        output valid,
        output command,
        output column,
        output row,
        output particle_kind,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  column,
        input  row,
        input  particle_kind,
        output ready
    );
endinterface

/* hw/rtl/fsg_row_if.sv */
interface fsg_row_if
    import fsg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ROW_NUMBER_W-1:0] row_number;
    logic [HALF_W-1:0]       cells_left_half;
    logic [HALF_W-1:0]       cells_right_half;
    logic                    last_row;

    modport source (
        output valid,
        output row_number,
        output cells_left_half,
        output cells_right_half,
        output last_row,
        input  ready
    );

    modport sink (
        input  valid,
        input  row_number,
        input  cells_left_half,
        input  cells_right_half,
        input  last_row,
        output ready
    );
endinterface

/* hw/rtl/falling_sand_grid_step.sv */
// Falling-sand grid engine, GRID_ROWS x GRID_COLUMNS two-bit cells
// (air, sand, water, cement), stored one grid row per memory word.
// cmd channel: place writes one cell (out-of-grid places are dropped);
// step emits the grid on the rows channel, one packed row per
// transaction (at most 32 rows, last_row on the final one), then
// advances one generation in place.
// cmd.ready is high only while the sequencer is idle.
// Place: busy for a read-modify-write of one row.
// Step: each emitted row is read (S_EMIT_RD) and loaded into the
// output register (S_EMIT_LOAD); then the generation runs: the
// move unit decides one cell per cycle against two old-row registers
// and swaps in two working-row registers; each finished row is written
// back and the row two below, if any, is fetched.
// Rows leave through an output register; a stalled receiver holds the
// emission loop at the current row, and the last row may still wait
// there while the generation runs and after the block is idle again.
// Reset clears per-row valid bits, so the grid reads as all air at once;
// there is no clearing pass.
module falling_sand_grid_step
    import fsg_pkg::*;
#(
    parameter int GRID_ROWS    = GRID_ROWS_DEFAULT,
    parameter int GRID_COLUMNS = GRID_COLUMNS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    fsg_cmd_if.sink   cmd,
    fsg_row_if.source rows
);

    localparam int RADDR_W   = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLUMNS);
    localparam int DATA_W    = 2 * GRID_COLUMNS;
    localparam int EMIT_ROWS = (GRID_ROWS < MAX_EMIT) ? GRID_ROWS : MAX_EMIT;
    localparam int PACK_W    = 2 * HALF_W;

    typedef logic [GRID_COLUMNS-1:0][1:0] grid_row_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLACE_WR,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_GEN_LD0,
        S_GEN_LD1,
        S_CELL,
        S_ROW_WR,
        S_SHIFT
    } state_t;

    state_t                  state_reg, state_next;
    logic [RADDR_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ROW_NUMBER_W-1:0] out_row_reg, out_row_next;
    logic [HALF_W-1:0]       out_left_reg, out_left_next;
    logic [HALF_W-1:0]       out_right_reg, out_right_next;
    logic                    out_last_reg, out_last_next;

    logic [COL_W-1:0]        place_col_reg, place_col_next;
    logic [KIND_W-1:0]       place_kind_reg, place_kind_next;

    grid_row_t cur_old_reg, cur_old_next;
    grid_row_t next_old_reg, next_old_next;
    grid_row_t cur_work_reg, cur_work_next;
    grid_row_t next_work_reg, next_work_next;

    logic               mem_wr_en;
    logic [RADDR_W-1:0] mem_wr_addr;
    logic [DATA_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [RADDR_W-1:0] mem_rd_addr;
    logic [DATA_W-1:0]  mem_rd_data;
    grid_row_t          rd_row;
    grid_row_t          place_row;
    logic [PACK_W-1:0]  rd_packed;

    logic               cmd_accept;
    logic               place_in_grid;
    logic               out_free;
    logic               last_col;
    logic               last_grid_row;
    logic               fetch_ahead;
    logic [COL_W-1:0]   col_m1;
    logic [COL_W-1:0]   col_p1;
    logic [COL_W-1:0]   tcol;
    logic               to_below;
    logic [1:0]         own_w;
    logic [1:0]         target_w;
    neighbor_t          nb;
    move_t              move;

    fsg_grid_mem #(
        .ROWS (GRID_ROWS),
        .COLS (GRID_COLUMNS)
    ) u_grid_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fsg_move_unit u_move_unit (
        .nb   (nb),
        .move (move)
    );

    assign rd_row    = grid_row_t'(mem_rd_data);
    assign rd_packed = PACK_W'(mem_rd_data);

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign place_in_grid = (32'(cmd.row) < GRID_ROWS) && (32'(cmd.column) < GRID_COLUMNS);

    assign rows.valid            = out_valid_reg;
    assign rows.row_number       = out_row_reg;
    assign rows.cells_left_half  = out_left_reg;
    assign rows.cells_right_half = out_right_reg;
    assign rows.last_row         = out_last_reg;
    assign out_free = !out_valid_reg || rows.ready;

    assign last_col      = (col_reg == COL_W'(GRID_COLUMNS - 1));
    assign last_grid_row = (row_reg == RADDR_W'(GRID_ROWS - 1));
    assign fetch_ahead   = (32'(row_reg) + 2) < GRID_ROWS;
    assign col_m1 = col_reg - COL_W'(1);
    assign col_p1 = col_reg + COL_W'(1);

    always_comb
    begin
        nb.own         = particle_t'(cur_old_reg[col_reg]);
        nb.below       = particle_t'(next_old_reg[col_reg]);
        nb.below_left  = particle_t'(next_old_reg[col_m1]);
        nb.below_right = particle_t'(next_old_reg[col_p1]);
        nb.left        = particle_t'(cur_old_reg[col_m1]);
        nb.right       = particle_t'(cur_old_reg[col_p1]);
        nb.has_below   = !last_grid_row;
        nb.has_left    = (col_reg != '0);
        nb.has_right   = !last_col;
    end

    always_comb
    begin
        case (move)
            MOVE_DOWN_LEFT, MOVE_LEFT:   tcol = col_m1;
            MOVE_DOWN_RIGHT, MOVE_RIGHT: tcol = col_p1;
            default:                     tcol = col_reg;
        endcase
        to_below = (move == MOVE_DOWN) || (move == MOVE_DOWN_LEFT)
                   || (move == MOVE_DOWN_RIGHT);
        own_w    = cur_work_reg[col_reg];
        target_w = to_below ? next_work_reg[tcol] : cur_work_reg[tcol];
    end

    always_comb
    begin
        place_row = rd_row;
        place_row[place_col_reg] = place_kind_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        out_valid_next  = out_valid_reg && !rows.ready;
        out_row_next    = out_row_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_last_next   = out_last_reg;
        place_col_next  = place_col_reg;
        place_kind_next = place_kind_reg;
        cur_old_next    = cur_old_reg;
        next_old_next   = next_old_reg;
        cur_work_next   = cur_work_reg;
        next_work_next  = next_work_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = row_reg;
        mem_wr_data     = DATA_W'(cur_work_reg);
        mem_rd_en       = 1'b0;
        mem_rd_addr     = row_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd.command == CMD_PLACE)
                    begin
                        if (place_in_grid)
                        begin
                            mem_rd_en       = 1'b1;
                            mem_rd_addr     = RADDR_W'(cmd.row);
                            row_next        = RADDR_W'(cmd.row);
                            place_col_next  = COL_W'(cmd.column);
                            place_kind_next = cmd.particle_kind;
                            state_next      = S_PLACE_WR;
                        end
                    end
                    else
                    begin
                        row_next   = '0;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_PLACE_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = DATA_W'(place_row);
                state_next  = S_IDLE;
            end
            S_EMIT_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_EMIT_LOAD;
            end
            S_EMIT_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = ROW_NUMBER_W'(row_reg);
                    out_left_next  = rd_packed[HALF_W-1:0];
                    out_right_next = rd_packed[PACK_W-1:HALF_W];
                    out_last_next  = (row_reg == RADDR_W'(EMIT_ROWS - 1));
                    if (row_reg == RADDR_W'(EMIT_ROWS - 1))
                    begin
                        row_next    = '0;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_next  = S_GEN_LD0;
                    end
                    else
                    begin
                        row_next   = row_reg + RADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_GEN_LD0:
            begin
                cur_old_next  = rd_row;
                cur_work_next = rd_row;
                mem_rd_en     = 1'b1;
                mem_rd_addr   = RADDR_W'(1);
                state_next    = S_GEN_LD1;
            end
            S_GEN_LD1:
            begin
                next_old_next  = rd_row;
                next_work_next = rd_row;
                col_next       = '0;
                state_next     = S_CELL;
            end
            S_CELL:
            begin
                if (move != MOVE_NONE)
                begin
                    cur_work_next[col_reg] = target_w;
                    if (to_below)
                    begin
                        next_work_next[tcol] = own_w;
                    end
                    else
                    begin
                        cur_work_next[tcol] = own_w;
                    end
                end
                if (last_col)
                begin
                    state_next = S_ROW_WR;
                end
                else
                begin
                    col_next = col_p1;
                end
            end
            S_ROW_WR:
            begin
                mem_wr_en = 1'b1;
                if (last_grid_row)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_rd_en   = fetch_ahead;
                    mem_rd_addr = row_reg + RADDR_W'(2);
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cur_old_next   = next_old_reg;
                cur_work_next  = next_work_reg;
                next_old_next  = rd_row;
                next_work_next = rd_row;
                row_next       = row_reg + RADDR_W'(1);
                col_next       = '0;
                state_next     = S_CELL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        place_col_reg  <= place_col_next;
        place_kind_reg <= place_kind_next;
        cur_old_reg    <= cur_old_next;
        next_old_reg   <= next_old_next;
        cur_work_reg   <= cur_work_next;
        next_work_reg  <= next_work_next;
    end

endmodule

/* hw/rtl/fsg_grid_mem.sv */
module fsg_grid_mem
    import fsg_pkg::*;
#(
    parameter int ROWS = GRID_ROWS_DEFAULT,
    parameter int COLS = GRID_COLUMNS_DEFAULT,
    localparam int ADDR_W = $clog2(ROWS),
    localparam int DATA_W = 2 * COLS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [DATA_W-1:0] rd_q_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // unwritten rows read as air
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

/* hw/rtl/fsg_move_unit.sv */
module fsg_move_unit
    import fsg_pkg::*;
(
    input  neighbor_t nb,
    output move_t     move
);

    logic is_sand;
    logic is_water;

    function automatic logic accepts(particle_t k, logic sand);
        return (k == KIND_AIR) || (sand && k == KIND_WATER);
    endfunction

    assign is_sand  = (nb.own == KIND_SAND);
    assign is_water = (nb.own == KIND_WATER);

    always_comb
    begin
        move = MOVE_NONE;
        if (nb.own inside {KIND_SAND, KIND_WATER})
        begin
            if (nb.has_below && accepts(nb.below, is_sand))
            begin
                move = MOVE_DOWN;
            end
            else if (nb.has_below && nb.has_left && accepts(nb.below_left, is_sand))
            begin
                move = MOVE_DOWN_LEFT;
            end
            else if (nb.has_below && nb.has_right && accepts(nb.below_right, is_sand))
            begin
                move = MOVE_DOWN_RIGHT;
            end
            else if (is_water && nb.has_left && nb.left == KIND_AIR)
            begin
                move = MOVE_LEFT;
            end
            else if (is_water && nb.has_right && nb.right == KIND_AIR)
            begin
                move = MOVE_RIGHT;
            end
        end
    end

endmodule
